FILE: design/cau_pkg.sv
package cau_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_MOD = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIVZ = 2'd2
  } status_e;

endpackage

FILE: design/cau_if.sv
interface cau_in_if #(
  parameter int W = cau_pkg::COMP_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic [2:0]          op;
  logic signed [W-1:0] a_re;
  logic signed [W-1:0] a_im;
  logic signed [W-1:0] b_re;
  logic signed [W-1:0] b_im;

  modport source (output valid, op, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, op, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if #(
  parameter int W = cau_pkg::COMP_WIDTH
) ();
  logic                valid;
  logic                ready;
  logic signed [W-1:0] res_re;
  logic signed [W-1:0] res_im;
  logic [1:0]          status;

  modport source (output valid, res_re, res_im, status, input ready);
  modport sink   (input valid, res_re, res_im, status, output ready);
endinterface

FILE: design/cau_front.sv
module cau_front #(
  parameter int W = cau_pkg::COMP_WIDTH,
  parameter int F = cau_pkg::FRAC_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [2:0]          op_i,
  input  logic signed [W-1:0] a_re_i,
  input  logic signed [W-1:0] a_im_i,
  input  logic signed [W-1:0] b_re_i,
  input  logic signed [W-1:0] b_im_i,
  output logic                valid_o,
  output logic [2:0]          op_o,
  output logic                neg_re_o,
  output logic                neg_im_o,
  output logic [2*W-1:0]      mag_re_o,
  output logic [2*W-1:0]      mag_im_o,
  output logic [2*W-1:0]      den_o
);
  localparam int XW = 2*W + 2;

  logic                  va_q, vb_q;
  logic [2:0]            opa_q, opb_q;
  logic signed [2*W-1:0] p_rr_q, p_ii_q, p_ri_q, p_ir_q, s_r_q, s_i_q;
  logic signed [W:0]     add_re_q, add_im_q, sub_re_q, sub_im_q;
  logic                  neg_re_d, neg_im_d, neg_re_q, neg_im_q;
  logic [2*W-1:0]        mag_re_d, mag_im_d, mag_re_q, mag_im_q, den_d, den_q;
  logic signed [XW-1:0]  x_re, x_im, ab_re, ab_im;

  // stage A: products and plain sums
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      opa_q    <= op_i;
      p_rr_q   <= a_re_i * b_re_i;
      p_ii_q   <= a_im_i * b_im_i;
      p_ri_q   <= a_re_i * b_im_i;
      p_ir_q   <= a_im_i * b_re_i;
      s_r_q    <= b_re_i * b_re_i;
      s_i_q    <= b_im_i * b_im_i;
      add_re_q <= (W+1)'(a_re_i) + (W+1)'(b_re_i);
      add_im_q <= (W+1)'(a_im_i) + (W+1)'(b_im_i);
      sub_re_q <= (W+1)'(a_re_i) - (W+1)'(b_re_i);
      sub_im_q <= (W+1)'(a_im_i) - (W+1)'(b_im_i);
      opb_q    <= opa_q;
      neg_re_q <= neg_re_d;
      neg_im_q <= neg_im_d;
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
      den_q    <= den_d;
    end
  end

  // stage B: combine to sign and magnitude, and form the divisor |b|^2
  always_comb begin
    x_re = '0;
    x_im = '0;
    unique case (opa_q)
      cau_pkg::OP_ADD: begin
        x_re = XW'(add_re_q);
        x_im = XW'(add_im_q);
      end
      cau_pkg::OP_SUB: begin
        x_re = XW'(sub_re_q);
        x_im = XW'(sub_im_q);
      end
      cau_pkg::OP_MUL: begin
        x_re = XW'(p_rr_q) - XW'(p_ii_q);
        x_im = XW'(p_ri_q) + XW'(p_ir_q);
      end
      cau_pkg::OP_DIV: begin
        x_re = XW'(p_rr_q) + XW'(p_ii_q);
        x_im = XW'(p_ir_q) - XW'(p_ri_q);
      end
      default: ;
    endcase
    ab_re    = x_re[XW-1] ? -x_re : x_re;
    ab_im    = x_im[XW-1] ? -x_im : x_im;
    mag_re_d = ab_re[2*W-1:0];
    mag_im_d = ab_im[2*W-1:0];
    if (opa_q == cau_pkg::OP_MUL) begin
      mag_re_d = mag_re_d >> F;
      mag_im_d = mag_im_d >> F;
    end
    neg_re_d = x_re[XW-1] && (mag_re_d != '0);
    neg_im_d = x_im[XW-1] && (mag_im_d != '0);
    den_d    = (2*W)'($unsigned(s_r_q)) + (2*W)'($unsigned(s_i_q));
  end

  assign valid_o  = vb_q;
  assign op_o     = opb_q;
  assign neg_re_o = neg_re_q;
  assign neg_im_o = neg_im_q;
  assign mag_re_o = mag_re_q;
  assign mag_im_o = mag_im_q;
  assign den_o    = den_q;
endmodule

FILE: design/cau_cell.sv
module cau_cell #(
  parameter int W   = cau_pkg::COMP_WIDTH,
  parameter int F   = cau_pkg::FRAC_BITS,
  parameter int IDX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [2:0]         op_i,
  input  logic               neg_re_i,
  input  logic               neg_im_i,
  input  logic [2*W-1:0]     mag_re_i,
  input  logic [2*W-1:0]     mag_im_i,
  input  logic [2*W-1:0]     den_i,
  input  logic [2*W:0]       rem_re_i,
  input  logic [2*W:0]       rem_im_i,
  input  logic [2*W+F-1:0]   q_re_i,
  input  logic [2*W+F-1:0]   q_im_i,
  input  logic [W+2:0]       srem_i,
  input  logic [W-1:0]       root_i,
  output logic               valid_o,
  output logic [2:0]         op_o,
  output logic               neg_re_o,
  output logic               neg_im_o,
  output logic [2*W-1:0]     mag_re_o,
  output logic [2*W-1:0]     mag_im_o,
  output logic [2*W-1:0]     den_o,
  output logic [2*W:0]       rem_re_o,
  output logic [2*W:0]       rem_im_o,
  output logic [2*W+F-1:0]   q_re_o,
  output logic [2*W+F-1:0]   q_im_o,
  output logic [W+2:0]       srem_o,
  output logic [W-1:0]       root_o
);
  localparam int QB  = 2*W + F;
  localparam int BIT = QB - 1 - IDX;

  logic [QB-1:0]  dd_re, dd_im;
  logic [2*W:0]   rs_re, rs_im, rem_re_d, rem_im_d, dn;
  logic [QB-1:0]  q_re_d, q_im_d;
  logic [W+2:0]   srem_d;
  logic [W-1:0]   root_d;

  // one restoring division step per lane, dividend is mag scaled by 2^F
  always_comb begin
    dd_re = QB'(mag_re_i) << F;
    dd_im = QB'(mag_im_i) << F;
    dn    = {1'b0, den_i};
    rs_re = {rem_re_i[2*W-1:0], dd_re[BIT]};
    rs_im = {rem_im_i[2*W-1:0], dd_im[BIT]};
    if (rs_re >= dn) begin
      rem_re_d = rs_re - dn;
      q_re_d   = {q_re_i[QB-2:0], 1'b1};
    end else begin
      rem_re_d = rs_re;
      q_re_d   = {q_re_i[QB-2:0], 1'b0};
    end
    if (rs_im >= dn) begin
      rem_im_d = rs_im - dn;
      q_im_d   = {q_im_i[QB-2:0], 1'b1};
    end else begin
      rem_im_d = rs_im;
      q_im_d   = {q_im_i[QB-2:0], 1'b0};
    end
  end

  // square root digit, two radicand bits a cell, first W cells only
  generate
    if (IDX < W) begin : g_sqrt
      localparam int PB = 2*(W - 1 - IDX);
      logic [W+2:0] sr, tr;
      always_comb begin
        sr = {srem_i[W:0], den_i[PB+1:PB]};
        tr = {1'b0, root_i, 2'b01};
        if (sr >= tr) begin
          srem_d = sr - tr;
          root_d = {root_i[W-2:0], 1'b1};
        end else begin
          srem_d = sr;
          root_d = {root_i[W-2:0], 1'b0};
        end
      end
    end else begin : g_pass
      assign srem_d = srem_i;
      assign root_d = root_i;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_o     <= op_i;
      neg_re_o <= neg_re_i;
      neg_im_o <= neg_im_i;
      mag_re_o <= mag_re_i;
      mag_im_o <= mag_im_i;
      den_o    <= den_i;
      rem_re_o <= rem_re_d;
      rem_im_o <= rem_im_d;
      q_re_o   <= q_re_d;
      q_im_o   <= q_im_d;
      srem_o   <= srem_d;
      root_o   <= root_d;
    end
  end
endmodule

FILE: design/complex_arith_unit_top.sv
// Channel  Dir  Fields                              Word accepted when
// in_i     in   op, a_re, a_im, b_re, b_im          valid && ready
// out_o    out  res_re, res_im, status              valid && ready
//
// One word a cycle while results are taken; front, then division cells (one
// quotient bit per cell, root digit in the first COMP_WIDTH), output register.
// Reset clears only the valid bits. The whole pipe moves as one: it holds
// while a result sits unread in the output register, and in_i.ready drops.
module complex_arith_unit_top #(
  parameter int COMP_WIDTH = cau_pkg::COMP_WIDTH,
  parameter int FRAC_BITS  = cau_pkg::FRAC_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);
  localparam int W  = COMP_WIDTH;
  localparam int F  = FRAC_BITS;
  localparam int QB = 2*W + F;
  localparam int NC = QB;

  logic en;

  logic              c_valid  [NC+1];
  logic [2:0]        c_op     [NC+1];
  logic              c_neg_re [NC+1];
  logic              c_neg_im [NC+1];
  logic [2*W-1:0]    c_mag_re [NC+1];
  logic [2*W-1:0]    c_mag_im [NC+1];
  logic [2*W-1:0]    c_den    [NC+1];
  logic [2*W:0]      c_rem_re [NC+1];
  logic [2*W:0]      c_rem_im [NC+1];
  logic [QB-1:0]     c_q_re   [NC+1];
  logic [QB-1:0]     c_q_im   [NC+1];
  logic [W+2:0]      c_srem   [NC+1];
  logic [W-1:0]      c_root   [NC+1];

  logic              out_valid_q;
  logic [W-1:0]      res_re_d, res_im_d, res_re_q, res_im_q;
  logic [1:0]        status_d, status_q;
  logic              neg_re, neg_im, sat;
  logic [QB-1:0]     m_re, m_im;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  cau_front #(.W(W), .F(F)) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_i.valid),
    .op_i     (in_i.op),
    .a_re_i   (in_i.a_re),
    .a_im_i   (in_i.a_im),
    .b_re_i   (in_i.b_re),
    .b_im_i   (in_i.b_im),
    .valid_o  (c_valid[0]),
    .op_o     (c_op[0]),
    .neg_re_o (c_neg_re[0]),
    .neg_im_o (c_neg_im[0]),
    .mag_re_o (c_mag_re[0]),
    .mag_im_o (c_mag_im[0]),
    .den_o    (c_den[0])
  );

  assign c_rem_re[0] = '0;
  assign c_rem_im[0] = '0;
  assign c_q_re[0]   = '0;
  assign c_q_im[0]   = '0;
  assign c_srem[0]   = '0;
  assign c_root[0]   = '0;

  for (genvar i = 0; i < NC; i++) begin : g_cell
    cau_cell #(.W(W), .F(F), .IDX(i)) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .en_i     (en),
      .valid_i  (c_valid[i]),
      .op_i     (c_op[i]),
      .neg_re_i (c_neg_re[i]),
      .neg_im_i (c_neg_im[i]),
      .mag_re_i (c_mag_re[i]),
      .mag_im_i (c_mag_im[i]),
      .den_i    (c_den[i]),
      .rem_re_i (c_rem_re[i]),
      .rem_im_i (c_rem_im[i]),
      .q_re_i   (c_q_re[i]),
      .q_im_i   (c_q_im[i]),
      .srem_i   (c_srem[i]),
      .root_i   (c_root[i]),
      .valid_o  (c_valid[i+1]),
      .op_o     (c_op[i+1]),
      .neg_re_o (c_neg_re[i+1]),
      .neg_im_o (c_neg_im[i+1]),
      .mag_re_o (c_mag_re[i+1]),
      .mag_im_o (c_mag_im[i+1]),
      .den_o    (c_den[i+1]),
      .rem_re_o (c_rem_re[i+1]),
      .rem_im_o (c_rem_im[i+1]),
      .q_re_o   (c_q_re[i+1]),
      .q_im_o   (c_q_im[i+1]),
      .srem_o   (c_srem[i+1]),
      .root_o   (c_root[i+1])
    );
  end

  // pick the result, then clamp to the component range
  always_comb begin
    neg_re   = 1'b0;
    neg_im   = 1'b0;
    m_re     = '0;
    m_im     = '0;
    status_d = cau_pkg::ST_OK;
    unique case (c_op[NC])
      cau_pkg::OP_ADD, cau_pkg::OP_SUB, cau_pkg::OP_MUL: begin
        neg_re = c_neg_re[NC];
        neg_im = c_neg_im[NC];
        m_re   = QB'(c_mag_re[NC]);
        m_im   = QB'(c_mag_im[NC]);
      end
      cau_pkg::OP_DIV: begin
        if (c_den[NC] == '0) begin
          status_d = cau_pkg::ST_DIVZ;
        end else begin
          neg_re = c_neg_re[NC];
          neg_im = c_neg_im[NC];
          m_re   = c_q_re[NC];
          m_im   = c_q_im[NC];
        end
      end
      cau_pkg::OP_MOD: begin
        m_re = QB'(c_root[NC]);
      end
      default: ;
    endcase
    neg_re = neg_re && (m_re != '0);
    neg_im = neg_im && (m_im != '0);
    sat    = 1'b0;
    if (!neg_re && m_re > QB'((1 << (W-1)) - 1)) begin
      m_re = QB'((1 << (W-1)) - 1);
      sat  = 1'b1;
    end
    if (neg_re && m_re > (QB'(1) << (W-1))) begin
      m_re = QB'(1) << (W-1);
      sat  = 1'b1;
    end
    if (!neg_im && m_im > QB'((1 << (W-1)) - 1)) begin
      m_im = QB'((1 << (W-1)) - 1);
      sat  = 1'b1;
    end
    if (neg_im && m_im > (QB'(1) << (W-1))) begin
      m_im = QB'(1) << (W-1);
      sat  = 1'b1;
    end
    res_re_d = neg_re ? W'(-m_re) : m_re[W-1:0];
    res_im_d = neg_im ? W'(-m_im) : m_im[W-1:0];
    if (status_d == cau_pkg::ST_OK && sat) begin
      status_d = cau_pkg::ST_SAT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c_valid[NC];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.res_re = res_re_q;
  assign out_o.res_im = res_im_q;
  assign out_o.status = status_q;
endmodule

FILE: dv/complex_arith_unit_top_tb.sv
module complex_arith_unit_top_tb;

  localparam int W         = cau_pkg::COMP_WIDTH;
  localparam int LATENCY   = 2*cau_pkg::COMP_WIDTH + cau_pkg::FRAC_BITS + 2;
  localparam int MAX_CYC   = 600000;
  localparam int N_RANDOM  = 1100;

  typedef struct packed {
    logic [2:0]          op;
    logic signed [W-1:0] a_re;
    logic signed [W-1:0] a_im;
    logic signed [W-1:0] b_re;
    logic signed [W-1:0] b_im;
  } cplx_word_t;

  typedef struct packed {
    logic signed [W-1:0] re;
    logic signed [W-1:0] im;
    logic [1:0]          status;
  } cplx_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  cau_in_if  #(.W(W)) in_if ();
  cau_out_if #(.W(W)) out_if ();

  complex_arith_unit_top #(
    .COMP_WIDTH(cau_pkg::COMP_WIDTH),
    .FRAC_BITS (cau_pkg::FRAC_BITS)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  cplx_word_t pending_words[$];
  cplx_res_t  expected_res[$];
  int         src_idle_pct = 0;
  int         snk_stall_pct = 0;
  int         mismatches = 0;
  int         cycles = 0;
  logic       in_taken = 1'b0;

  function automatic longint clamp_comp(longint v, inout logic sat);
    longint maxpos = (longint'(1) <<< (W-1)) - 1;
    if (v > maxpos) begin
      sat = 1'b1;
      return maxpos;
    end
    if (v < -maxpos - 1) begin
      sat = 1'b1;
      return -maxpos - 1;
    end
    return v;
  endfunction

  // shift right by the fraction bits, rounding toward zero
  function automatic longint trunc_frac(longint v);
    return (v < 0) ? -((-v) >>> cau_pkg::FRAC_BITS) : (v >>> cau_pkg::FRAC_BITS);
  endfunction

  function automatic cplx_res_t calc_result(cplx_word_t w);
    longint ar, ai, br, bi, re, im, den, root, cand;
    logic sat;
    logic [1:0] st;
    cplx_res_t r;
    ar = w.a_re; ai = w.a_im; br = w.b_re; bi = w.b_im;
    re = 0; im = 0; sat = 1'b0; st = cau_pkg::ST_OK;
    den = br*br + bi*bi;
    case (w.op)
      cau_pkg::OP_ADD: begin re = ar + br; im = ai + bi; end
      cau_pkg::OP_SUB: begin re = ar - br; im = ai - bi; end
      cau_pkg::OP_MUL: begin
        re = trunc_frac(ar*br - ai*bi);
        im = trunc_frac(ar*bi + ai*br);
      end
      cau_pkg::OP_DIV: begin
        if (den == 0) st = cau_pkg::ST_DIVZ;
        else begin
          re = ((ar*br + ai*bi) <<< cau_pkg::FRAC_BITS) / den;
          im = ((ai*br - ar*bi) <<< cau_pkg::FRAC_BITS) / den;
        end
      end
      cau_pkg::OP_MOD: begin
        root = 0;
        for (int i = 20; i >= 0; i--) begin
          cand = root | (longint'(1) <<< i);
          if (cand*cand <= den) root = cand;
        end
        re = root;
      end
      default: ;
    endcase
    r.re = W'(clamp_comp(re, sat));
    r.im = W'(clamp_comp(im, sat));
    r.status = (st == cau_pkg::ST_OK && sat) ? cau_pkg::ST_SAT : st;
    return r;
  endfunction

  function automatic logic [W-1:0] rand_comp();
    case ($urandom_range(0, 4))
      0: return W'($urandom_range(0, 2) == 0 ? 0 :
                   ($urandom_range(0, 1) ? 32767 : -32768));
      1: return W'($signed($urandom_range(0, 1024)) - 512);
      2: return W'($signed($urandom_range(0, 8192)) - 4096);
      default: return W'($urandom);
    endcase
  endfunction

  function automatic cplx_word_t rand_word();
    cplx_word_t w;
    w.op   = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
    w.a_re = rand_comp();
    w.a_im = rand_comp();
    w.b_re = rand_comp();
    w.b_im = rand_comp();
    if (w.op == cau_pkg::OP_DIV && $urandom_range(0, 9) == 0) begin
      w.b_re = '0;
      w.b_im = '0;
    end
    return w;
  endfunction

  function automatic cplx_word_t mk(logic [2:0] op, int ar, int ai, int br, int bi);
    cplx_word_t w;
    w.op = op; w.a_re = W'(ar); w.a_im = W'(ai); w.b_re = W'(br); w.b_im = W'(bi);
    return w;
  endfunction

  // driver: source side changes on the falling edge
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken || !in_if.valid) begin
        if (pending_words.size() > 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          {in_if.op, in_if.a_re, in_if.a_im, in_if.b_re, in_if.b_im} <= pending_words.pop_front();
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end
  end

  // monitor: both channels sampled on the rising edge
  always @(posedge clk_i) begin
    cplx_res_t got, want;
    cycles <= cycles + 1;
    in_taken <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready)
      expected_res.push_back(calc_result({in_if.op, in_if.a_re, in_if.a_im,
                                          in_if.b_re, in_if.b_im}));
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.res_re, out_if.res_im, out_if.status};
      if (expected_res.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result word %h", got);
      end else begin
        want = expected_res.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp re %0d im %0d st %0d, got re %0d im %0d st %0d",
                     want.re, want.im, want.status, got.re, got.im, got.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (cycles >= MAX_CYC) begin
      $display("complex_arith_unit_top test failed");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = '0;
    in_if.a_re = '0; in_if.a_im = '0; in_if.b_re = '0; in_if.b_im = '0;
    out_if.ready = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    // directed: every opcode, extremes, saturation, divide by zero
    for (int op = 0; op < 8; op++)
      pending_words.push_back(mk(3'(op), 32767, -32768, 32767, -32768));
    pending_words.push_back(mk(cau_pkg::OP_ADD, 256, -256, 512, 128));
    pending_words.push_back(mk(cau_pkg::OP_SUB, -32768, 32767, 1, -1));
    pending_words.push_back(mk(cau_pkg::OP_MUL, -1, 1, 1, 1));
    pending_words.push_back(mk(cau_pkg::OP_MUL, -32768, -32768, -32768, -32768));
    pending_words.push_back(mk(cau_pkg::OP_MUL, 384, -640, 256, 100));
    pending_words.push_back(mk(cau_pkg::OP_DIV, 512, 256, 0, 0));
    pending_words.push_back(mk(cau_pkg::OP_DIV, 0, 0, 0, 0));
    pending_words.push_back(mk(cau_pkg::OP_DIV, 32767, 32767, 1, 0));
    pending_words.push_back(mk(cau_pkg::OP_DIV, -700, 300, 256, -512));
    pending_words.push_back(mk(cau_pkg::OP_DIV, 1, 0, -32768, -32768));
    pending_words.push_back(mk(cau_pkg::OP_MOD, 0, 0, 768, 1024));
    pending_words.push_back(mk(cau_pkg::OP_MOD, 0, 0, -32768, -32768));
    pending_words.push_back(mk(cau_pkg::OP_MOD, 0, 0, 0, 0));
    pending_words.push_back(mk(cau_pkg::OP_MOD, 5, 5, -3, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 80; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 80; end
        default: begin src_idle_pct = 27; snk_stall_pct = 27; end
      endcase
      for (int i = 0; i < N_RANDOM/4; i++) pending_words.push_back(rand_word());
      wait (pending_words.size() == 0 && !in_if.valid);
    end
    wait (expected_res.size() == 0);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("complex_arith_unit_top test passed");
    end else begin
      $display("complex_arith_unit_top test failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
design/cau_pkg.sv
design/cau_if.sv
design/cau_front.sv
design/cau_cell.sv
design/complex_arith_unit_top.sv
dv/complex_arith_unit_top_tb.sv
